>>> src/domino_profile_count_engine_macros.svh
// ----------------------------------------------------------------------------
// domino_profile_count_engine_macros
// assertion macros used by dpce_checker
// ----------------------------------------------------------------------------
`ifndef DOMINO_PROFILE_COUNT_ENGINE_MACROS_SVH
`define DOMINO_PROFILE_COUNT_ENGINE_MACROS_SVH

// implication checked out of reset
`define DPCE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// property checked also while reset is asserted
`define DPCE_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/dpce_pkg.sv
// ----------------------------------------------------------------------------
// dpce_pkg
// types and codes of the domino profile count engine
// ----------------------------------------------------------------------------
package dpce_pkg;

  localparam int FUNC_W        = 3;
  localparam int COLUMN_W      = 3;
  localparam int PROF_IDX_W    = 7;
  localparam int COUNT_VALUE_W = 32;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_INIT   = 3'd0,
    FN_CLEAR  = 3'd1,
    FN_TOGGLE = 3'd2,
    FN_RPASS  = 3'd3,
    FN_READ   = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_TG_RD,
    ST_TG_WA,
    ST_TG_WB,
    ST_RP_RD,
    ST_RP_WR,
    ST_RD_ISSUE,
    ST_RD_HOLD
  } state_t;

endpackage

>>> src/dpce_ram.sv
// ----------------------------------------------------------------------------
// dpce_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
module dpce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> src/domino_profile_count_engine.sv
// sequencing: accept in ST_IDLE, then init writes all 2^COLUMNS entries, clear the
// 2^(COLUMNS-1) with the column bit low, toggle reads a pair then writes each half, row
// pass reads then writes (COLUMNS-1)*2^(COLUMNS-2) targets; a read registers its result
// in ST_RD_HOLD once the output register is free; items: one at a time, in_tready low
// until the op ends, unused codes leave in_tready high; reset: synchronous active-low rst_n,
// then an init sweep over all 2^COLUMNS entries (all-ones entry one, rest zero), in_tready low
// ----------------------------------------------------------------------------
// domino_profile_count_engine
// broken-profile domino tiling count table with a sequenced shared adder
// ----------------------------------------------------------------------------
module domino_profile_count_engine #(
  parameter int COLUMNS    = 7,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // column [2:0], profile_index [9:3], zero [15:10]
  input  logic [2:0]  in_tuser,   // func [2:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // count_value [31:0]
);

  localparam int ADDR_W = COLUMNS;
  localparam int DEPTH  = 1 << COLUMNS;
  localparam int POS_W  = $clog2(COLUMNS);

  // sweep end counts
  localparam logic [ADDR_W-1:0] LAST_ALL  = ADDR_W'((1 << COLUMNS) - 1);
  localparam logic [ADDR_W-1:0] LAST_HALF = ADDR_W'((1 << (COLUMNS - 1)) - 1);
  localparam logic [ADDR_W-1:0] LAST_QTR  = ADDR_W'((1 << (COLUMNS - 2)) - 1);
  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(COLUMNS - 2);

  // field split
  logic [dpce_pkg::FUNC_W-1:0]     in_func;
  logic [dpce_pkg::COLUMN_W-1:0]   in_column;
  logic [dpce_pkg::PROF_IDX_W-1:0] in_profile_index;
  logic                            in_accept;
  logic                            col_ok;

  assign in_func          = in_tuser;
  assign in_column        = in_tdata[2:0];
  assign in_profile_index = in_tdata[9:3];
  assign in_accept        = in_tvalid && in_tready;
  assign col_ok           = 32'(in_column) < 32'(COLUMNS);

  // sequencer state
  dpce_pkg::state_t  state_r, state_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;       // sweep counter over the entries touched
  logic [POS_W-1:0]  pos_r, pos_nxt;       // column bit, or low bit of the pair in row pass
  logic [ADDR_W-1:0] idx_r, idx_nxt;       // read address
  logic [COUNT_BITS-1:0] hold_r, hold_nxt; // second half of a toggle swap
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;

  // table ram signals
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr_a, ram_raddr_b;
  logic [COUNT_BITS-1:0] ram_rdata_a, ram_rdata_b;

  // address generation: a zero (or a pair of bits) spliced in at pos_r
  logic [ADDR_W-1:0] low_mask;
  logic [ADDR_W-1:0] pair_mask;
  logic [ADDR_W-1:0] addr_p0;   // entry with the column bit clear
  logic [ADDR_W-1:0] addr_p1;   // its partner with the column bit set
  logic [ADDR_W-1:0] addr_pr;   // row pass target, both pair bits set
  logic [ADDR_W-1:0] addr_q;    // row pass source, both pair bits clear
  logic [COUNT_BITS-1:0] sum;   // the shared adder
  logic              slot_free;

  assign low_mask  = (ADDR_W'(1) << pos_r) - ADDR_W'(1);
  assign pair_mask = ADDR_W'(3) << pos_r;
  assign addr_p0   = ((cnt_r & ~low_mask) << 1) | (cnt_r & low_mask);
  assign addr_p1   = addr_p0 | (ADDR_W'(1) << pos_r);
  assign addr_pr   = ((cnt_r & ~low_mask) << 2) | (cnt_r & low_mask) | pair_mask;
  assign addr_q    = addr_pr & ~pair_mask;
  assign sum       = ram_rdata_a + ram_rdata_b;
  assign slot_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dpce_pkg::ST_INIT: begin
        if (cnt_r == LAST_ALL) begin
          state_nxt = dpce_pkg::ST_IDLE;
        end
      end
      dpce_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (in_func)
            dpce_pkg::FN_INIT:   state_nxt = dpce_pkg::ST_INIT;
            dpce_pkg::FN_CLEAR:  state_nxt = col_ok ? dpce_pkg::ST_CLEAR : dpce_pkg::ST_IDLE;
            dpce_pkg::FN_TOGGLE: state_nxt = col_ok ? dpce_pkg::ST_TG_RD : dpce_pkg::ST_IDLE;
            dpce_pkg::FN_RPASS:  state_nxt = dpce_pkg::ST_RP_RD;
            dpce_pkg::FN_READ:   state_nxt = dpce_pkg::ST_RD_ISSUE;
            default:             state_nxt = dpce_pkg::ST_IDLE;  // unused codes do nothing
          endcase
        end
      end
      dpce_pkg::ST_CLEAR: begin
        if (cnt_r == LAST_HALF) begin
          state_nxt = dpce_pkg::ST_IDLE;
        end
      end
      dpce_pkg::ST_TG_RD: state_nxt = dpce_pkg::ST_TG_WA;
      dpce_pkg::ST_TG_WA: state_nxt = dpce_pkg::ST_TG_WB;
      dpce_pkg::ST_TG_WB: begin
        state_nxt = (cnt_r == LAST_HALF) ? dpce_pkg::ST_IDLE : dpce_pkg::ST_TG_RD;
      end
      dpce_pkg::ST_RP_RD: state_nxt = dpce_pkg::ST_RP_WR;
      dpce_pkg::ST_RP_WR: begin
        if (cnt_r == LAST_QTR && pos_r == LAST_POS) begin
          state_nxt = dpce_pkg::ST_IDLE;
        end else begin
          state_nxt = dpce_pkg::ST_RP_RD;
        end
      end
      dpce_pkg::ST_RD_ISSUE: state_nxt = dpce_pkg::ST_RD_HOLD;
      dpce_pkg::ST_RD_HOLD: begin
        if (slot_free) begin
          state_nxt = dpce_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dpce_pkg::ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = cnt_r;
    ram_wdata     = '0;
    ram_raddr_a   = addr_p0;
    ram_raddr_b   = addr_p1;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      dpce_pkg::ST_INIT: begin
        // all-ones profile starts at one, everything else at zero
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = (cnt_r == LAST_ALL) ? COUNT_BITS'(1) : '0;
        cnt_nxt   = cnt_r + ADDR_W'(1);
      end
      dpce_pkg::ST_IDLE: begin
        if (in_accept) begin
          cnt_nxt = '0;
          pos_nxt = (in_func == dpce_pkg::FN_RPASS) ? '0 : POS_W'(in_column);
          idx_nxt = ADDR_W'(in_profile_index);
        end
      end
      dpce_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_p0;
        ram_wdata = '0;
        cnt_nxt   = cnt_r + ADDR_W'(1);
      end
      dpce_pkg::ST_TG_RD: begin
        ram_raddr_a = addr_p0;
        ram_raddr_b = addr_p1;
      end
      dpce_pkg::ST_TG_WA: begin
        ram_we    = 1'b1;
        ram_waddr = addr_p1;
        ram_wdata = ram_rdata_a;
        hold_nxt  = ram_rdata_b;
      end
      dpce_pkg::ST_TG_WB: begin
        ram_we    = 1'b1;
        ram_waddr = addr_p0;
        ram_wdata = hold_r;
        cnt_nxt   = cnt_r + ADDR_W'(1);
      end
      dpce_pkg::ST_RP_RD: begin
        ram_raddr_a = addr_pr;
        ram_raddr_b = addr_q;
      end
      dpce_pkg::ST_RP_WR: begin
        // target += source, wraps at COUNT_BITS
        ram_we    = 1'b1;
        ram_waddr = addr_pr;
        ram_wdata = sum;
        if (cnt_r == LAST_QTR) begin
          cnt_nxt = '0;
          pos_nxt = pos_r + POS_W'(1);
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      dpce_pkg::ST_RD_ISSUE: begin
        ram_raddr_a = idx_r;
      end
      dpce_pkg::ST_RD_HOLD: begin
        // address held so the read data stays put while the output is busy
        ram_raddr_a = idx_r;
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 32'(ram_rdata_a);
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dpce_pkg::ST_INIT;
      cnt_r       <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    hold_r     <= hold_nxt;
    out_data_r <= out_data_nxt;
  end

  dpce_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  assign in_tready  = (state_r == dpce_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> src/dpce_checker.sv
// ----------------------------------------------------------------------------
// dpce_checker
// port-level checks of the domino profile count engine
// ----------------------------------------------------------------------------
`include "domino_profile_count_engine_macros.svh"

module dpce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  logic rd_accept;
  logic other_accept;

  assign rd_accept    = in_tvalid && in_tready && (in_tuser == dpce_pkg::FN_READ);
  assign other_accept = in_tvalid && in_tready && (in_tuser != dpce_pkg::FN_READ);

  // a stalled result holds
  `DPCE_ASSERT_IMP(a_out_hold, out_tvalid && !out_tready, ##1 (out_tvalid && $stable(out_tdata)), "stalled result changed")

  // reset starts the init sweep, no item taken right after it
  `DPCE_ASSERT_ANY(a_reset_busy, (!rst_n |=> !in_tready), "ready right after reset")

  // a read keeps the block busy until its result is out
  `DPCE_ASSERT_IMP(a_read_busy, rd_accept, ##1 !in_tready, "ready right after a read")

  // only reads produce results
  `DPCE_ASSERT_IMP(a_no_spurious, other_accept && !out_tvalid, ##1 !out_tvalid, "result without a read")

endmodule

bind domino_profile_count_engine dpce_checker u_dpce_checker (.*);

>>> tb/domino_profile_count_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// domino_profile_count_engine_tb
// self-checking bench: a directed table, then random single ops and
// row-building episodes, each read checked against a typed count or a
// mirror of the count table kept in the bench
// ----------------------------------------------------------------------------
module domino_profile_count_engine_tb;

  localparam int NUM_COLUMNS   = 7;
  localparam int TABLE_DEPTH   = 1 << NUM_COLUMNS;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int PAUSE_EVERY   = 500;
  localparam int IDLE_LIMIT    = 5000;
  localparam int DRAIN_CYCLES  = 400;

  // func codes the block ignores
  localparam logic [dpce_pkg::FUNC_W-1:0] FN_SPARE_A = 3'd5;
  localparam logic [dpce_pkg::FUNC_W-1:0] FN_SPARE_B = 3'd6;
  localparam logic [dpce_pkg::FUNC_W-1:0] FN_SPARE_C = 3'd7;
  // first column code past the table width
  localparam logic [dpce_pkg::COLUMN_W-1:0] COLUMN_OFF = 3'd7;

  typedef struct {
    logic [dpce_pkg::FUNC_W-1:0]        fn;
    logic [dpce_pkg::COLUMN_W-1:0]      col;
    logic [dpce_pkg::PROF_IDX_W-1:0]    idx;
    bit                                 typed;
    logic [dpce_pkg::COUNT_VALUE_W-1:0] typed_count;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // column [2:0], profile_index [9:3], zero [15:10]
  logic [2:0]  in_tuser = '0;   // func [2:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // count_value [31:0]

  // mirror of the block's count table
  logic [dpce_pkg::COUNT_VALUE_W-1:0] count_mirror [TABLE_DEPTH];
  // counts still owed by the block, oldest first
  logic [dpce_pkg::COUNT_VALUE_W-1:0] owed_counts [$];
  table_row_t                         directed_rows [$];

  int  mismatch_count = 0;
  int  counts_checked = 0;
  int  idle_cycles = 0;
  int  applied_ops = 0;
  int  n_init = 0, n_clear = 0, n_toggle = 0, n_rpass = 0, n_read = 0, n_ignored = 0;
  bit  sender_calm = 1'b0;
  bit  receiver_calm = 1'b0;

  domino_profile_count_engine #(
    .COLUMNS    (NUM_COLUMNS),
    .COUNT_BITS (dpce_pkg::COUNT_VALUE_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table mirror: applies one op and yields the count a read returns
  task automatic apply_profile_op(input logic [dpce_pkg::FUNC_W-1:0] fn,
                                  input logic [dpce_pkg::COLUMN_W-1:0] col,
                                  input logic [dpce_pkg::PROF_IDX_W-1:0] idx,
                                  output bit gives_count,
                                  output logic [dpce_pkg::COUNT_VALUE_W-1:0] count);
    logic [dpce_pkg::PROF_IDX_W-1:0]    p;
    logic [dpce_pkg::PROF_IDX_W-1:0]    m;
    logic [dpce_pkg::PROF_IDX_W-1:0]    pair;
    logic [dpce_pkg::COUNT_VALUE_W-1:0] held;
    gives_count = 1'b0;
    count = '0;
    case (fn)
      dpce_pkg::FN_INIT: begin
        for (int k = 0; k < TABLE_DEPTH; k++) count_mirror[k] = '0;
        count_mirror[TABLE_DEPTH-1] = dpce_pkg::COUNT_VALUE_W'(1);
      end
      dpce_pkg::FN_CLEAR: begin
        if (col < NUM_COLUMNS)
          for (int k = 0; k < TABLE_DEPTH; k++) begin
            p = k[dpce_pkg::PROF_IDX_W-1:0];
            if (!p[col]) count_mirror[k] = '0;
          end
      end
      dpce_pkg::FN_TOGGLE: begin
        if (col < NUM_COLUMNS) begin
          m = dpce_pkg::PROF_IDX_W'(1) << col;
          // swap each pair once, visiting it from its upper member
          for (int k = 0; k < TABLE_DEPTH; k++) begin
            p = k[dpce_pkg::PROF_IDX_W-1:0];
            if ((p & m) != '0) begin
              held = count_mirror[p];
              count_mirror[p] = count_mirror[p ^ m];
              count_mirror[p ^ m] = held;
            end
          end
        end
      end
      dpce_pkg::FN_RPASS: begin
        // sweeps run in column order, later sweeps see earlier sums
        for (int i = 0; i < NUM_COLUMNS - 1; i++) begin
          pair = dpce_pkg::PROF_IDX_W'(3) << i;
          for (int k = 0; k < TABLE_DEPTH; k++) begin
            p = k[dpce_pkg::PROF_IDX_W-1:0];
            if ((p & pair) == pair)
              count_mirror[p] = count_mirror[p] + count_mirror[p & ~pair];
          end
        end
      end
      dpce_pkg::FN_READ: begin
        gives_count = 1'b1;
        count = count_mirror[idx];
      end
      default: ;
    endcase
  endtask

  // random gap length, mostly short with the odd long one
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // entered and left at a falling edge; updates the mirror on acceptance
  task automatic send_op(input logic [dpce_pkg::FUNC_W-1:0] fn,
                         input logic [dpce_pkg::COLUMN_W-1:0] col,
                         input logic [dpce_pkg::PROF_IDX_W-1:0] idx, input bit typed,
                         input logic [dpce_pkg::COUNT_VALUE_W-1:0] typed_count);
    int                                 gap;
    bit                                 gives_count;
    logic [dpce_pkg::COUNT_VALUE_W-1:0] count;
    if ($urandom_range(0, 149) == 0) sender_calm = ($urandom_range(0, 2) == 0);
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {6'b0, idx, col};
    do @(posedge clk); while (!in_tready);
    apply_profile_op(fn, col, idx, gives_count, count);
    if (gives_count) owed_counts.insert(owed_counts.size(), typed ? typed_count : count);
    if (fn > dpce_pkg::FN_READ ||
        ((fn == dpce_pkg::FN_CLEAR || fn == dpce_pkg::FN_TOGGLE) && col >= NUM_COLUMNS)) begin
      n_ignored++;
    end else begin
      applied_ops++;
      case (fn)
        dpce_pkg::FN_INIT:   n_init++;
        dpce_pkg::FN_CLEAR:  n_clear++;
        dpce_pkg::FN_TOGGLE: n_toggle++;
        dpce_pkg::FN_RPASS:  n_rpass++;
        default:             n_read++;
      endcase
    end
    @(negedge clk);
  endtask

  // sender holds off until every owed count is back
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (owed_counts.size() != 0);
  endtask

  task automatic add_row(input logic [dpce_pkg::FUNC_W-1:0] fn,
                         input logic [dpce_pkg::COLUMN_W-1:0] col,
                         input logic [dpce_pkg::PROF_IDX_W-1:0] idx, input bit typed,
                         input logic [dpce_pkg::COUNT_VALUE_W-1:0] typed_count);
    table_row_t row;
    row.fn = fn;
    row.col = col;
    row.idx = idx;
    row.typed = typed;
    row.typed_count = typed_count;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // result side: random stalls with calm stretches, decided at the falling edge
  initial begin
    int stall_left;
    int rx_cycles;
    stall_left = 0;
    rx_cycles = 0;
    forever begin
      @(negedge clk);
      rx_cycles++;
      if (rx_cycles % 256 == 0) receiver_calm = ($urandom_range(0, 2) == 0);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        stall_left = pick_gap(receiver_calm);
        out_tready <= (stall_left == 0);
      end
    end
  end

  // result checker, compares each accepted count with the oldest one owed
  always @(posedge clk) begin
    logic [dpce_pkg::COUNT_VALUE_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_counts.size() == 0) begin
        mismatch_count++;
        $display("%0t: count_value mismatch, expected no count got %08h", $time, out_tdata);
      end else begin
        want = owed_counts.pop_front();
        counts_checked++;
        if (out_tdata !== want) begin
          mismatch_count++;
          $display("%0t: count_value mismatch, expected %08h got %08h", $time, want, out_tdata);
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("domino_profile_count_engine verification failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    table_row_t row;
    int         next_pause;
    int         r;
    int         n_reads;

    // reset state: only the all-ones profile holds a count
    add_row(dpce_pkg::FN_READ,   3'd0,       7'd127, 1'b1, 32'd1);
    add_row(dpce_pkg::FN_READ,   3'd0,       7'd0,   1'b1, 32'd0);
    // spare func codes, all field bits high, nothing happens
    add_row(FN_SPARE_A,          COLUMN_OFF, 7'd127, 1'b0, '0);
    add_row(FN_SPARE_B,          COLUMN_OFF, 7'd127, 1'b0, '0);
    add_row(FN_SPARE_C,          COLUMN_OFF, 7'd127, 1'b0, '0);
    // toggling column 0 moves the single count down one profile
    add_row(dpce_pkg::FN_TOGGLE, 3'd0,       7'd0,   1'b0, '0);
    add_row(dpce_pkg::FN_READ,   3'd0,       7'd126, 1'b1, 32'd1);
    add_row(dpce_pkg::FN_READ,   3'd0,       7'd127, 1'b1, 32'd0);
    // column past the table width leaves clear and toggle idle
    add_row(dpce_pkg::FN_TOGGLE, COLUMN_OFF, 7'd0,   1'b0, '0);
    add_row(dpce_pkg::FN_CLEAR,  COLUMN_OFF, 7'd0,   1'b0, '0);
    add_row(dpce_pkg::FN_READ,   3'd0,       7'd126, 1'b1, 32'd1);
    // clear on column 0 wipes the profile with that bit low
    add_row(dpce_pkg::FN_CLEAR,  3'd0,       7'd0,   1'b0, '0);
    add_row(dpce_pkg::FN_READ,   3'd0,       7'd126, 1'b1, 32'd0);
    // small row build, predicted
    add_row(dpce_pkg::FN_INIT,   3'd0,       7'd0,   1'b0, '0);
    add_row(dpce_pkg::FN_TOGGLE, 3'd6,       7'd0,   1'b0, '0);
    add_row(dpce_pkg::FN_TOGGLE, 3'd5,       7'd0,   1'b0, '0);
    add_row(dpce_pkg::FN_RPASS,  3'd0,       7'd0,   1'b0, '0);
    add_row(dpce_pkg::FN_READ,   3'd0,       7'd127, 1'b0, '0);
    add_row(dpce_pkg::FN_READ,   3'd0,       7'd31,  1'b0, '0);
    add_row(dpce_pkg::FN_TOGGLE, 3'd0,       7'd0,   1'b0, '0);
    add_row(dpce_pkg::FN_RPASS,  3'd0,       7'd0,   1'b0, '0);
    add_row(dpce_pkg::FN_READ,   3'd0,       7'd30,  1'b0, '0);
    add_row(dpce_pkg::FN_CLEAR,  3'd6,       7'd0,   1'b0, '0);
    add_row(dpce_pkg::FN_READ,   3'd0,       7'd126, 1'b0, '0);
    add_row(dpce_pkg::FN_INIT,   3'd0,       7'd0,   1'b0, '0);
    add_row(dpce_pkg::FN_READ,   3'd0,       7'd127, 1'b1, 32'd1);

    // mirror starts in the reset state
    for (int k = 0; k < TABLE_DEPTH; k++) count_mirror[k] = '0;
    count_mirror[TABLE_DEPTH-1] = dpce_pkg::COUNT_VALUE_W'(1);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      send_op(row.fn, row.col, row.idx, row.typed, row.typed_count);
    end
    hold_until_drained();

    // random part: well-formed row episodes mixed with single ops and noise
    applied_ops = 0;
    next_pause = PAUSE_EVERY;
    while (applied_ops < RANDOM_ITEMS) begin
      if (applied_ops >= next_pause) begin
        hold_until_drained();
        next_pause += PAUSE_EVERY;
      end
      if ($urandom_range(0, 3) == 0) begin
        // one row of the tiling walk: vertical toggles and random clears, then the pass
        if ($urandom_range(0, 7) == 0)
          send_op(dpce_pkg::FN_INIT, 3'($urandom), 7'($urandom), 1'b0, '0);
        for (int c = 0; c < NUM_COLUMNS; c++) begin
          if ($urandom_range(0, 1) == 0)
            send_op(dpce_pkg::FN_TOGGLE, 3'(c), 7'($urandom), 1'b0, '0);
          if ($urandom_range(0, 5) == 0)
            send_op(dpce_pkg::FN_CLEAR, 3'(c), 7'($urandom), 1'b0, '0);
        end
        send_op(dpce_pkg::FN_RPASS, 3'($urandom), 7'($urandom), 1'b0, '0);
        n_reads = $urandom_range(1, 4);
        repeat (n_reads) send_op(dpce_pkg::FN_READ, 3'($urandom), 7'($urandom), 1'b0, '0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45)      send_op(dpce_pkg::FN_READ,   3'($urandom), 7'($urandom), 1'b0, '0);
        else if (r < 57) send_op(dpce_pkg::FN_RPASS,  3'($urandom), 7'($urandom), 1'b0, '0);
        else if (r < 72) send_op(dpce_pkg::FN_TOGGLE, 3'($urandom), 7'($urandom), 1'b0, '0);
        else if (r < 82) send_op(dpce_pkg::FN_CLEAR,  3'($urandom), 7'($urandom), 1'b0, '0);
        else if (r < 87) send_op(dpce_pkg::FN_INIT,   3'($urandom), 7'($urandom), 1'b0, '0);
        else send_op(3'($urandom_range(FN_SPARE_A, FN_SPARE_C)), 3'($urandom),
                     7'($urandom), 1'b0, '0);
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d init, %0d clear, %0d toggle, %0d row pass, %0d read, %0d ignored",
             n_init, n_clear, n_toggle, n_rpass, n_read, n_ignored);
    $display("%0d counts compared, %0d mismatches", counts_checked, mismatch_count);
    if (mismatch_count == 0 && owed_counts.size() == 0) begin
      $display("domino_profile_count_engine verification clean");
    end else begin
      $display("domino_profile_count_engine verification failed");
    end
    $finish;
  end

endmodule

>>> domino_profile_count_engine.f
+incdir+src
src/dpce_pkg.sv
src/dpce_ram.sv
src/domino_profile_count_engine.sv
src/dpce_checker.sv
tb/domino_profile_count_engine_tb.sv
